@@ hw/rtl/lxh_pkg.sv @@
package lxh_pkg;

  // Default sizes
  localparam int MAX_COLUMNS_DEF   = 64;
  localparam int MAX_ROWS_DEF      = 64;
  localparam int MAX_PARTICLES_DEF = 1024;

  // Field widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int PART_W  = 10;
  localparam int COORD_W = 6;
  localparam int U_W     = 16;
  localparam int WIND_W  = 32;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PLACE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HOP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

  // Hop direction, top two bits of the uniform fraction
  localparam logic [1:0] DIR_ROW_UP = 2'd0;
  localparam logic [1:0] DIR_ROW_DN = 2'd1;
  localparam logic [1:0] DIR_COL_UP = 2'd2;
  localparam logic [1:0] DIR_COL_DN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic sweep;   // clearing pass after reset
    logic accept;  // latch a new transaction
    logic rd_pos;  // position data back, issue occupancy read
    logic decide;  // occupancy data back, commit
    logic finish;  // result on the ports, free the old site
  } lxh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
  } lxh_sts_t;

endpackage

@@ hw/rtl/lxh_ram.sv @@
module lxh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/lxh_ctrl.sv @@
module lxh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_strobe,
  output lxh_pkg::lxh_cmd_t cmd,
  input  lxh_pkg::lxh_sts_t sts
);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_POS   = 5'b00100,
    S_OCC   = 5'b01000,
    S_CLR   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // A new transaction may enter while the previous result is shown
  assign busy   = !((state_r == S_IDLE) || (state_r == S_CLR));
  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_POS;
      end
      S_POS: state_nxt = S_OCC;
      S_OCC: state_nxt = S_CLR;
      S_CLR: begin
        state_nxt = accept ? S_POS : S_IDLE;
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign cmd.sweep  = (state_r == S_SWEEP);
  assign cmd.accept = accept;
  assign cmd.rd_pos = (state_r == S_POS);
  assign cmd.decide = (state_r == S_OCC);
  assign cmd.finish = (state_r == S_CLR);
  assign out_strobe = (state_r == S_CLR);

  // Checks
  a_clr_after_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> $past(state_r == S_OCC))
    else $error("result shown without a commit cycle");

  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && sts.sweep_last) |=> (state_r == S_IDLE))
    else $error("clearing pass did not end");

  a_accept_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_POS))
    else $error("accepted transaction not started");

endmodule

@@ hw/rtl/lxh_dp.sv @@
module lxh_dp #(
  parameter int MAX_COLUMNS   = lxh_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = lxh_pkg::MAX_ROWS_DEF,
  parameter int MAX_PARTICLES = lxh_pkg::MAX_PARTICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lxh_pkg::lxh_cmd_t                   cmd,
  output lxh_pkg::lxh_sts_t                   sts,
  input  logic [lxh_pkg::REQ_W-1:0]           in_req_type,
  input  logic [lxh_pkg::PART_W-1:0]          in_particle,
  input  logic [lxh_pkg::COORD_W-1:0]         in_place_column,
  input  logic [lxh_pkg::COORD_W-1:0]         in_place_row,
  input  logic [lxh_pkg::U_W-1:0]             in_u_fraction,
  output logic                                out_moved,
  output logic [lxh_pkg::COORD_W-1:0]         out_new_column,
  output logic [lxh_pkg::COORD_W-1:0]         out_new_row,
  output logic signed [lxh_pkg::WIND_W-1:0]   out_winding,
  output logic [lxh_pkg::COORD_W-1:0]         out_start_column,
  input  logic                                cfg_we,
  input  logic [lxh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lxh_pkg::CFG_W-1:0]           cfg_data
);

  // Register values clamp to what seven bits and the array allow
  localparam int COL_LIM   = (MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS;
  localparam int ROW_LIM   = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int CW        = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
  localparam int RW        = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
  localparam int PAW       = $clog2(MAX_PARTICLES);
  localparam int NSITES    = MAX_COLUMNS * MAX_ROWS;
  localparam int SAW       = $clog2(NSITES);
  localparam int PDW       = 1 + CW + RW;
  localparam int SWEEP_LEN = (NSITES > MAX_PARTICLES) ? NSITES : MAX_PARTICLES;
  localparam int SWW       = $clog2(SWEEP_LEN);
  localparam int CFW       = lxh_pkg::CFG_W;
  localparam logic [CFW-1:0] LEN_MAX = CFW'(COL_LIM);
  localparam logic [CFW-1:0] CNT_MAX = CFW'(ROW_LIM);
  localparam logic [CFW-1:0] LEN_RST = CFW'((COL_LIM < 64) ? COL_LIM : 64);
  localparam logic [CFW-1:0] CNT_RST = CFW'((ROW_LIM < 64) ? ROW_LIM : 64);
  localparam logic signed [lxh_pkg::WIND_W-1:0] WIND_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [lxh_pkg::WIND_W-1:0] WIND_MIN = 32'sh8000_0000;

  function automatic logic [CFW-1:0] clamp_reg(input logic [CFW-1:0] v,
                                               input logic [CFW-1:0] lim);
    logic [CFW-1:0] x;
    x = (v == '0) ? CFW'(1) : v;
    if (x > lim) x = lim;
    return x;
  endfunction

  // Configuration
  logic [CFW-1:0] len_r, cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RST;
      cnt_r <= CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lxh_pkg::CFG_ROW_LENGTH: len_r <= clamp_reg(cfg_data, LEN_MAX);
        lxh_pkg::CFG_ROW_COUNT:  cnt_r <= clamp_reg(cfg_data, CNT_MAX);
        default: ;
      endcase
    end
  end

  // Clearing pass counter
  logic [SWW-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_r + SWW'(1);
    end
  end

  assign sts.sweep_last = (sweep_r == SWW'(SWEEP_LEN - 1));

  // Transaction latch
  logic [lxh_pkg::REQ_W-1:0]   req_r;
  logic [PAW-1:0]              part_r;
  logic                        oor_r;
  logic                        tracer_r;
  logic [lxh_pkg::COORD_W-1:0] pc_r, pr_r;
  logic [1:0]                  dir_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_req_type;
      part_r   <= PAW'(in_particle);
      oor_r    <= (32'(in_particle) >= 32'(MAX_PARTICLES));
      tracer_r <= (in_particle == '0);
      pc_r     <= in_place_column;
      pr_r     <= in_place_row;
      dir_r    <= in_u_fraction[lxh_pkg::U_W-1 -: 2];
    end
  end

  // Memories
  logic           pos_we;
  logic [PAW-1:0] pos_addr;
  logic [PDW-1:0] pos_wdata, pos_rdata;
  logic           occ_we;
  logic [SAW-1:0] occ_addr;
  logic [0:0]     occ_wdata, occ_rdata;

  lxh_ram #(.WIDTH(PDW), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .addr  (pos_addr),
    .wdata (pos_wdata),
    .rdata (pos_rdata)
  );

  lxh_ram #(.WIDTH(1), .DEPTH(NSITES)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .addr  (occ_addr),
    .wdata (occ_wdata),
    .rdata (occ_rdata)
  );

  // Position read decode and neighbor with wraparound
  logic          rd_valid;
  logic [CW-1:0] rd_col;
  logic [RW-1:0] rd_row;
  logic [7:0]    len8, cnt8, col8, row8;
  logic [7:0]    col_inc, row_inc, col_up, col_dn, row_up, row_dn;
  logic [7:0]    hop_col, hop_row;
  logic [SAW-1:0] hop_site, place_site, old_site, rd_site;

  assign {rd_valid, rd_col, rd_row} = pos_rdata;
  assign len8    = 8'(len_r);
  assign cnt8    = 8'(cnt_r);
  assign col8    = 8'(rd_col);
  assign row8    = 8'(rd_row);
  assign col_inc = col8 + 8'd1;
  assign row_inc = row8 + 8'd1;
  assign col_up  = (col_inc >= len8) ? 8'd0 : col_inc;
  assign row_up  = (row_inc >= cnt8) ? 8'd0 : row_inc;
  assign col_dn  = (col8 == 8'd0) ? (len8 - 8'd1) : (col8 - 8'd1);
  assign row_dn  = (row8 == 8'd0) ? (cnt8 - 8'd1) : (row8 - 8'd1);

  always_comb begin
    hop_col = col8;
    hop_row = row8;
    case (dir_r)
      lxh_pkg::DIR_ROW_UP: hop_row = row_up;
      lxh_pkg::DIR_ROW_DN: hop_row = row_dn;
      lxh_pkg::DIR_COL_UP: hop_col = col_up;
      lxh_pkg::DIR_COL_DN: hop_col = col_dn;
      default: ;
    endcase
  end

  // Site index = row * MAX_COLUMNS + column
  assign hop_site   = SAW'(32'(hop_row) * MAX_COLUMNS + 32'(hop_col));
  assign place_site = SAW'(32'(pr_r) * MAX_COLUMNS + 32'(pc_r));
  assign old_site   = SAW'(32'(rd_row) * MAX_COLUMNS + 32'(rd_col));
  assign rd_site    = (req_r == lxh_pkg::REQ_PLACE) ? place_site : hop_site;

  // Position stage registers
  logic           cur_valid_r;
  logic [CW-1:0]  cur_col_r, new_col_r;
  logic [RW-1:0]  cur_row_r, new_row_r;
  logic [SAW-1:0] old_addr_r, tgt_addr_r;
  logic           place_ok_r, hop_ok_r, wrap_rt_r, wrap_lf_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_pos) begin
      cur_valid_r <= rd_valid;
      cur_col_r   <= rd_col;
      cur_row_r   <= rd_row;
      new_col_r   <= CW'(hop_col);
      new_row_r   <= RW'(hop_row);
      old_addr_r  <= old_site;
      tgt_addr_r  <= rd_site;
      place_ok_r  <= (8'(pc_r) < len8) && (8'(pr_r) < cnt8);
      hop_ok_r    <= rd_valid && (col8 < len8) && (row8 < cnt8) &&
                     (req_r == lxh_pkg::REQ_HOP) && !oor_r;
      wrap_rt_r   <= (dir_r == lxh_pkg::DIR_COL_UP) && (col_inc >= len8);
      wrap_lf_r   <= (dir_r == lxh_pkg::DIR_COL_DN) && (col8 == 8'd0);
    end
  end

  // Commit decision
  logic                               moved_nxt, pos_commit, occ_set, clr_en_nxt;
  logic [CW-1:0]                      wr_col;
  logic [RW-1:0]                      wr_row;
  logic [lxh_pkg::COORD_W-1:0]        rep_col, rep_row, start_col_nxt;
  logic signed [lxh_pkg::WIND_W-1:0]  winding_nxt;
  logic signed [lxh_pkg::WIND_W-1:0]  winding_r;
  logic [lxh_pkg::COORD_W-1:0]        start_col_r;

  always_comb begin
    moved_nxt     = 1'b0;
    pos_commit    = 1'b0;
    occ_set       = 1'b0;
    clr_en_nxt    = 1'b0;
    wr_col        = new_col_r;
    wr_row        = new_row_r;
    rep_col       = lxh_pkg::COORD_W'(cur_col_r);
    rep_row       = lxh_pkg::COORD_W'(cur_row_r);
    winding_nxt   = winding_r;
    start_col_nxt = start_col_r;
    case (req_r)
      lxh_pkg::REQ_RESET: begin
        start_col_nxt = lxh_pkg::COORD_W'(cur_col_r);
        winding_nxt   = '0;
      end
      lxh_pkg::REQ_PLACE: begin
        if (oor_r) begin
          rep_col = '0;
          rep_row = '0;
        end else if (place_ok_r && !occ_rdata[0]) begin
          moved_nxt  = 1'b1;
          pos_commit = 1'b1;
          occ_set    = 1'b1;
          clr_en_nxt = cur_valid_r;
          wr_col     = CW'(pc_r);
          wr_row     = RW'(pr_r);
          rep_col    = pc_r;
          rep_row    = pr_r;
        end
      end
      lxh_pkg::REQ_HOP: begin
        if (oor_r) begin
          rep_col = '0;
          rep_row = '0;
        end else if (hop_ok_r && !occ_rdata[0]) begin
          moved_nxt  = 1'b1;
          pos_commit = 1'b1;
          occ_set    = 1'b1;
          clr_en_nxt = 1'b1;
          rep_col    = lxh_pkg::COORD_W'(new_col_r);
          rep_row    = lxh_pkg::COORD_W'(new_row_r);
          // tracer winding across the side edges, saturating
          if (tracer_r && wrap_rt_r && (winding_r != WIND_MAX)) begin
            winding_nxt = winding_r + 32'sd1;
          end else if (tracer_r && wrap_lf_r && (winding_r != WIND_MIN)) begin
            winding_nxt = winding_r - 32'sd1;
          end
        end
      end
      default: begin
        if (oor_r) begin
          rep_col = '0;
          rep_row = '0;
        end
      end
    endcase
  end

  // Result and tracer registers
  logic                        out_moved_r, clr_en_r;
  logic [lxh_pkg::COORD_W-1:0] out_col_r, out_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      winding_r   <= '0;
      start_col_r <= '0;
      clr_en_r    <= 1'b0;
    end else if (cmd.decide) begin
      winding_r   <= winding_nxt;
      start_col_r <= start_col_nxt;
      clr_en_r    <= clr_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_moved_r <= moved_nxt;
      out_col_r   <= rep_col;
      out_row_r   <= rep_row;
    end
  end

  assign out_moved        = out_moved_r;
  assign out_new_column   = out_col_r;
  assign out_new_row      = out_row_r;
  assign out_winding      = winding_r;
  assign out_start_column = start_col_r;

  // Position port: sweep, commit write, else read for the incoming transaction
  always_comb begin
    pos_we    = 1'b0;
    pos_addr  = (in_req_type == lxh_pkg::REQ_RESET) ? '0 : PAW'(in_particle);
    pos_wdata = {1'b1, wr_col, wr_row};
    if (cmd.sweep) begin
      pos_we    = (32'(sweep_r) < 32'(MAX_PARTICLES));
      pos_addr  = sweep_r[PAW-1:0];
      pos_wdata = '0;
    end else if (cmd.decide) begin
      pos_we   = pos_commit;
      pos_addr = part_r;
    end
  end

  // Occupancy port: sweep, target read, set new site, clear old site
  always_comb begin
    occ_we    = 1'b0;
    occ_addr  = rd_site;
    occ_wdata = 1'b0;
    if (cmd.sweep) begin
      occ_we   = 1'b1;
      occ_addr = sweep_r[SAW-1:0];
    end else if (cmd.decide) begin
      occ_we    = occ_set;
      occ_addr  = tgt_addr_r;
      occ_wdata = 1'b1;
    end else if (cmd.finish) begin
      occ_we   = clr_en_r;
      occ_addr = old_addr_r;
    end
  end

  // Checks
  a_wind_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(winding_r) |-> $past(cmd.decide))
    else $error("winding changed outside a commit");

  a_pos_in_lattice: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && pos_commit) |-> ((8'(wr_col) < len8) && (8'(wr_row) < cnt8)))
    else $error("particle written outside the lattice");

  a_sites_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && clr_en_r) |-> (old_addr_r != tgt_addr_r))
    else $error("freed site equals newly taken site");

endmodule

@@ hw/rtl/lattice_exclusion_hop.sv @@
// Result: it is on the out_ ports, with out_strobe high, in S_CLR, which follows S_POS and
//   S_OCC after the edge that accepts start; the receiver cannot stall it.
// Start is taken again in the strobe cycle, but not while a transaction is in S_POS or S_OCC.
//   Position read, occupancy read, then commit and old-site free on single-port RAMs.
// Reset: synchronous, active low; then a clearing pass over every occupancy site and
//   every position entry with busy high; cfg writes are taken.
module lattice_exclusion_hop #(
  parameter int MAX_COLUMNS   = lxh_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = lxh_pkg::MAX_ROWS_DEF,
  parameter int MAX_PARTICLES = lxh_pkg::MAX_PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lxh_pkg::REQ_W-1:0]         in_req_type,
  input  logic [lxh_pkg::PART_W-1:0]        in_particle,
  input  logic [lxh_pkg::COORD_W-1:0]       in_place_column,
  input  logic [lxh_pkg::COORD_W-1:0]       in_place_row,
  input  logic [lxh_pkg::U_W-1:0]           in_u_fraction,
  output logic                              out_strobe,
  output logic                              out_moved,
  output logic [lxh_pkg::COORD_W-1:0]       out_new_column,
  output logic [lxh_pkg::COORD_W-1:0]       out_new_row,
  output logic signed [lxh_pkg::WIND_W-1:0] out_winding,
  output logic [lxh_pkg::COORD_W-1:0]       out_start_column,
  input  logic                              cfg_we,
  input  logic [lxh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lxh_pkg::CFG_W-1:0]         cfg_data
);

  lxh_pkg::lxh_cmd_t cmd;
  lxh_pkg::lxh_sts_t sts;

  // Sequencer
  lxh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Memories, neighbor logic and result registers
  lxh_dp #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_particle      (in_particle),
    .in_place_column  (in_place_column),
    .in_place_row     (in_place_row),
    .in_u_fraction    (in_u_fraction),
    .out_moved        (out_moved),
    .out_new_column   (out_new_column),
    .out_new_row      (out_new_row),
    .out_winding      (out_winding),
    .out_start_column (out_start_column),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule
